### rtl/wavhp_pkg.sv
// shared types and constants for the wav header parser
package wavhp_pkg;

    // magic words, byte 0 of the file word at index 0
    localparam logic [3:0][7:0] MAGIC_RIFF = {8'h46, 8'h46, 8'h49, 8'h52};
    localparam logic [3:0][7:0] MAGIC_WAVE = {8'h45, 8'h56, 8'h41, 8'h57};
    localparam logic [3:0][7:0] MAGIC_FMT  = {8'h20, 8'h74, 8'h6D, 8'h66};
    localparam logic [3:0][7:0] MAGIC_DATA = {8'h61, 8'h74, 8'h61, 8'h64};

    // fixed header offsets
    localparam logic [31:0] POS_WAVE_FIRST  = 32'd8;
    localparam logic [31:0] POS_CHUNK_FIRST = 32'd12;
    localparam logic [31:0] POS_FMT_LAST    = 32'd15;
    localparam logic [31:0] POS_FORMAT_LO   = 32'd20;
    localparam logic [31:0] POS_FORMAT_HI   = 32'd21;
    localparam logic [31:0] POS_CHAN_LO     = 32'd22;
    localparam logic [31:0] POS_CHAN_HI     = 32'd23;
    localparam logic [31:0] POS_RATE_FIRST  = 32'd24;
    localparam logic [31:0] POS_RATE_LAST   = 32'd27;
    localparam logic [31:0] POS_BITS_LO     = 32'd34;
    localparam logic [31:0] POS_BITS_HI     = 32'd35;
    localparam logic [31:0] POS_HDR_LAST    = 32'd43;
    localparam logic [31:0] POS_MAX         = 32'hFFFF_FFFF;

    localparam logic [15:0] PCM_FORMAT   = 16'd1;
    localparam logic [7:0]  CHAN_STEREO  = 8'd2;
    localparam logic [7:0]  BITS_WIDE    = 8'd16;
    localparam logic [2:0]  HDR_IDX_LAST = 3'd7;

    // per-request control from the sequencer to the field and chunk units
    typedef struct packed {
        logic        active;    // request is parsed (no verdict yet)
        logic        restart;   // final byte taken, return to reset state
        logic [31:0] pos;       // byte position of this request
        logic [7:0]  data;      // byte of this request
    } wavhp_ctl_t;

    // captured format fields
    typedef struct packed {
        logic        fail;
        logic [31:0] rate;
        logic [1:0]  channels;
        logic [4:0]  bits;
        logic [1:0]  shift;
    } wavhp_fmt_t;

    // chunk walk status after this request
    typedef struct packed {
        logic        seen;
        logic [31:0] start;
        logic [31:0] length;
    } wavhp_chunk_t;

endpackage

### rtl/wavhp_if.sv
// stream interfaces for the byte input and the result output
interface wavhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wavhp_result_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [31:0] sample_rate;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] data_offset;
    logic [31:0] frame_total;

    modport source (output valid, output header_ok, output sample_rate,
                    output channel_count, output sample_bits, output data_offset,
                    output frame_total, input ready);
    modport sink   (input valid, input header_ok, input sample_rate,
                    input channel_count, input sample_bits, input data_offset,
                    input frame_total, output ready);
endinterface

### rtl/wavhp_fields.sv
// fixed-offset header checks and format field capture
module wavhp_fields (
    input  logic                clk,
    input  logic                rst_n,
    input  wavhp_pkg::wavhp_ctl_t ctl,
    output wavhp_pkg::wavhp_fmt_t fmt
);
    import wavhp_pkg::*;

    logic [7:0]       fmt_lo_reg, fmt_lo_next;
    logic [7:0]       chan_lo_reg, chan_lo_next;
    logic [7:0]       bits_lo_reg, bits_lo_next;
    logic [3:0][7:0]  rate_reg, rate_next;
    logic             fail;
    logic [31:0]      p;
    logic [7:0]       b;
    logic [15:0]      word;
    logic [31:0]      rate_off;
    logic [31:0]      wave_off;
    logic [31:0]      fmt_off;

    assign p        = ctl.pos;
    assign b        = ctl.data;
    assign rate_off = p - POS_RATE_FIRST;
    assign wave_off = p - POS_WAVE_FIRST;
    assign fmt_off  = p - POS_CHUNK_FIRST;

    // magic and format checks, field capture
    always_comb
    begin
        fail         = 1'b0;
        fmt_lo_next  = fmt_lo_reg;
        chan_lo_next = chan_lo_reg;
        bits_lo_next = bits_lo_reg;
        rate_next    = rate_reg;
        word         = 16'd0;
        if (p < 32'd4)
        begin
            fail = (b != MAGIC_RIFF[p[1:0]]);
        end
        else if (p >= POS_WAVE_FIRST && p < POS_CHUNK_FIRST)
        begin
            fail = (b != MAGIC_WAVE[wave_off[1:0]]);
        end
        else if (p >= POS_CHUNK_FIRST && p <= POS_FMT_LAST)
        begin
            fail = (b != MAGIC_FMT[fmt_off[1:0]]);
        end
        else if (p == POS_FORMAT_LO)
        begin
            fmt_lo_next = b;
        end
        else if (p == POS_FORMAT_HI)
        begin
            word = {b, fmt_lo_reg};
            fail = (word != PCM_FORMAT);
        end
        else if (p == POS_CHAN_LO)
        begin
            chan_lo_next = b;
        end
        else if (p == POS_CHAN_HI)
        begin
            word = {b, chan_lo_reg};
            fail = (word != 16'd1) && (word != 16'd2);
        end
        else if (p >= POS_RATE_FIRST && p <= POS_RATE_LAST)
        begin
            rate_next[rate_off[1:0]] = b;
        end
        else if (p == POS_BITS_LO)
        begin
            bits_lo_next = b;
        end
        else if (p == POS_BITS_HI)
        begin
            word = {b, bits_lo_reg};
            fail = (word != 16'd8) && (word != 16'd16);
        end
    end

    // field registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_lo_reg  <= '0;
            chan_lo_reg <= '0;
            bits_lo_reg <= '0;
            rate_reg    <= '0;
        end
        else if (ctl.restart)
        begin
            fmt_lo_reg  <= '0;
            chan_lo_reg <= '0;
            bits_lo_reg <= '0;
            rate_reg    <= '0;
        end
        else if (ctl.active)
        begin
            fmt_lo_reg  <= fmt_lo_next;
            chan_lo_reg <= chan_lo_next;
            bits_lo_reg <= bits_lo_next;
            rate_reg    <= rate_next;
        end
    end

    // values seen by the verdict; the checks have passed once ok is possible
    assign fmt.fail     = fail;
    assign fmt.rate     = rate_reg;
    assign fmt.channels = chan_lo_reg[1:0];
    assign fmt.bits     = bits_lo_reg[4:0];
    assign fmt.shift    = {1'b0, chan_lo_reg == CHAN_STEREO}
                        + {1'b0, bits_lo_reg == BITS_WIDE};

endmodule

### rtl/wavhp_chunk.sv
// chunk list walker: skips chunks until the data chunk header
module wavhp_chunk (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wavhp_pkg::wavhp_ctl_t   ctl,
    output wavhp_pkg::wavhp_chunk_t info
);
    import wavhp_pkg::*;

    logic [2:0]      idx_reg, idx_next;
    logic            is_data_reg, is_data_next;
    logic [3:0][7:0] len_reg, len_next;
    logic [31:0]     skip_reg, skip_next;
    logic            seen_reg, seen_next;
    logic [31:0]     start_reg, start_next;
    logic [31:0]     dlen_reg, dlen_next;
    logic [31:0]     full_len;

    assign full_len = {ctl.data, len_reg[2], len_reg[1], len_reg[0]};

    // one header byte or one skipped byte per request
    always_comb
    begin
        idx_next     = idx_reg;
        is_data_next = is_data_reg;
        len_next     = len_reg;
        skip_next    = skip_reg;
        seen_next    = seen_reg;
        start_next   = start_reg;
        dlen_next    = dlen_reg;
        if (ctl.active && ctl.pos >= POS_CHUNK_FIRST && !seen_reg)
        begin
            if (skip_reg != 32'd0)
            begin
                skip_next = skip_reg - 32'd1;
            end
            else if (idx_reg == HDR_IDX_LAST)
            begin
                if (is_data_reg)
                begin
                    seen_next  = 1'b1;
                    start_next = ctl.pos + 32'd1;
                    dlen_next  = full_len;
                end
                else
                begin
                    skip_next = full_len;
                end
                len_next     = '0;
                is_data_next = 1'b1;
                idx_next     = 3'd0;
            end
            else
            begin
                if (!idx_reg[2])
                begin
                    is_data_next = is_data_reg && (ctl.data == MAGIC_DATA[idx_reg[1:0]]);
                end
                else
                begin
                    len_next[idx_reg[1:0]] = ctl.data;
                end
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            is_data_reg <= 1'b1;
            len_reg     <= '0;
            skip_reg    <= '0;
            seen_reg    <= 1'b0;
            start_reg   <= '0;
            dlen_reg    <= '0;
        end
        else if (ctl.restart)
        begin
            idx_reg     <= '0;
            is_data_reg <= 1'b1;
            len_reg     <= '0;
            skip_reg    <= '0;
            seen_reg    <= 1'b0;
            start_reg   <= '0;
            dlen_reg    <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            is_data_reg <= is_data_next;
            len_reg     <= len_next;
            skip_reg    <= skip_next;
            seen_reg    <= seen_next;
            start_reg   <= start_next;
            dlen_reg    <= dlen_next;
        end
    end

    assign info.seen   = seen_next;
    assign info.start  = start_next;
    assign info.length = dlen_next;

endmodule

### rtl/wav_header_parser.sv
// top level of the wav header parser
// Usage:
//   byte_in carries the file one byte per request, from offset zero, with
//   end_of_file set on the final byte. result_out carries one verdict per
//   file: header_ok with rate, channels, bits, data offset and frame count,
//   or a rejection with all fields zero.
// Timing:
//   one byte per cycle sustained while result_out is not stalled. A request
//   is taken into the input register, then the field and chunk units update
//   and the verdict is loaded into the result register. The verdict comes
//   on the byte that fails a check, on offset 43 (or the later data chunk
//   header end) for success, or on the final byte. Bytes after the verdict
//   are consumed and ignored until the final byte.
// Reset and stall:
//   rst_n clears the parser to offset zero with no verdict pending. After
//   the final byte the parser restarts on its own for the next file.
//   When result_out is stalled with a result held, the input register
//   still fills, and byte_in deasserts ready until the result is taken.
module wav_header_parser (
    input  logic          clk,
    input  logic          rst_n,
    wavhp_byte_if.sink    byte_in,
    wavhp_result_if.source result_out
);
    import wavhp_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eof_reg;

    // sequencer state
    logic [31:0] pos_reg, pos_next;
    logic        verdict_reg, verdict_next;

    // result register
    logic        out_valid_reg;
    logic        ok_reg;
    logic [31:0] rate_reg;
    logic [1:0]  chan_reg;
    logic [4:0]  bits_reg;
    logic [31:0] offset_reg;
    logic [31:0] frames_reg;

    logic         step;
    logic         emit_now;
    logic         emit_ok;
    logic         load;
    wavhp_ctl_t   ctl;
    wavhp_fmt_t   fmt;
    wavhp_chunk_t chunk;

    assign step          = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.file_byte;
            in_eof_reg  <= byte_in.end_of_file;
        end
    end

    assign ctl.active  = step && !verdict_reg;
    assign ctl.restart = step && in_eof_reg;
    assign ctl.pos     = pos_reg;
    assign ctl.data    = in_byte_reg;

    wavhp_fields u_fields (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .fmt   (fmt)
    );

    wavhp_chunk u_chunk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .info  (chunk)
    );

    // verdict for this request
    assign emit_ok  = !fmt.fail && chunk.seen && (pos_reg >= POS_HDR_LAST);
    assign emit_now = ctl.active && (fmt.fail || emit_ok);
    assign load     = emit_now || (step && in_eof_reg && !verdict_reg);

    // position and verdict tracking
    always_comb
    begin
        pos_next     = pos_reg;
        verdict_next = verdict_reg;
        if (step)
        begin
            if (in_eof_reg)
            begin
                pos_next     = '0;
                verdict_next = 1'b0;
            end
            else if (!verdict_reg)
            begin
                verdict_next = emit_now;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            verdict_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            verdict_reg <= verdict_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (emit_now && emit_ok)
            begin
                ok_reg     <= 1'b1;
                rate_reg   <= fmt.rate;
                chan_reg   <= fmt.channels;
                bits_reg   <= fmt.bits;
                offset_reg <= chunk.start;
                frames_reg <= chunk.length >> fmt.shift;
            end
            else
            begin
                ok_reg     <= 1'b0;
                rate_reg   <= '0;
                chan_reg   <= '0;
                bits_reg   <= '0;
                offset_reg <= '0;
                frames_reg <= '0;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.header_ok     = ok_reg;
    assign result_out.sample_rate   = rate_reg;
    assign result_out.channel_count = chan_reg;
    assign result_out.sample_bits   = bits_reg;
    assign result_out.data_offset   = offset_reg;
    assign result_out.frame_total   = frames_reg;

    // accepted results carry a legal format
    a_ok_channels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |-> chan_reg == 2'd1 || chan_reg == 2'd2)
        else $error("ok result with bad channel count");

    a_ok_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |-> bits_reg == 5'd8 || bits_reg == 5'd16)
        else $error("ok result with bad sample bits");

    // rejections carry zero rate, offset and frame fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> rate_reg == 32'd0 && offset_reg == 32'd0
                                     && frames_reg == 32'd0)
        else $error("rejection with nonzero fields");

    // final byte returns the sequencer to offset zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_eof_reg |=> pos_reg == 32'd0 && !verdict_reg)
        else $error("parser did not restart after final byte");

    // no second verdict for the same file
    a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_reg && step && !in_eof_reg |-> !load)
        else $error("second verdict in one file");

endmodule
